// ----- sv/imurpp_pkg.sv -----
// ----------------------------------------------------------------------------
// imurpp_pkg
// Shared types and constants of the sensor report packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package imurpp_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int LEN_W       = 16;
    localparam int KIND_W      = 2;
    localparam int WORD_COUNT  = 10;
    localparam int CAP_DEPTH   = 8;
    localparam int CAP_IDX_W   = $clog2(CAP_DEPTH);

    localparam logic [BYTE_W-1:0] CHANNEL_REPORTS = 8'd2;
    localparam logic [BYTE_W-1:0] ID_ROTATION     = 8'h05;
    localparam logic [BYTE_W-1:0] ID_ACCEL        = 8'h01;
    localparam logic [BYTE_W-1:0] ID_GYRO         = 8'h02;
    localparam logic [LEN_W-1:0]  LEN_ROTATION    = 16'd19;
    localparam logic [LEN_W-1:0]  LEN_TRIPLE      = 16'd17;
    localparam logic [LEN_W-1:0]  LEN_MIN         = 16'd5;
    localparam logic [LEN_W-1:0]  FIRST_KEPT      = 16'd11;

    localparam int QUAT_BASE  = 0;
    localparam int ACCEL_BASE = 4;
    localparam int GYRO_BASE  = 7;

    localparam logic [KIND_W-1:0] KIND_ROTATION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GYRO     = 2'd2;

    typedef logic [WORD_COUNT-1:0][WORD_W-1:0] word_set_t;

    typedef struct packed {
        logic [KIND_W-1:0] update_kind;
        word_set_t         words;
        logic              rotation_valid;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/imurpp_if.sv -----
// ----------------------------------------------------------------------------
// imurpp_if
// Byte input channel and result channel of the sensor report packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface imurpp_in_if;
    import imurpp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface imurpp_out_if;
    import imurpp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        update_kind;
    logic signed [WORD_W-1:0] quat_i;
    logic signed [WORD_W-1:0] quat_j;
    logic signed [WORD_W-1:0] quat_k;
    logic signed [WORD_W-1:0] quat_real;
    logic signed [WORD_W-1:0] accel_x;
    logic signed [WORD_W-1:0] accel_y;
    logic signed [WORD_W-1:0] accel_z;
    logic signed [WORD_W-1:0] gyro_x;
    logic signed [WORD_W-1:0] gyro_y;
    logic signed [WORD_W-1:0] gyro_z;
    logic                     rotation_valid;

    modport source (
        output valid, output update_kind,
        output quat_i, output quat_j, output quat_k, output quat_real,
        output accel_x, output accel_y, output accel_z,
        output gyro_x, output gyro_y, output gyro_z,
        output rotation_valid,
        input  ready
    );
    modport sink (
        input  valid, input update_kind,
        input  quat_i, input quat_j, input quat_k, input quat_real,
        input  accel_x, input accel_y, input accel_z,
        input  gyro_x, input gyro_y, input gyro_z,
        input  rotation_valid,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/imu_report_packet_parser.sv -----
// ----------------------------------------------------------------------------
// imu_report_packet_parser
// Parses framed sensor report packets byte by byte and emits sample updates.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle. Every byte is decoded in the cycle it
// is accepted: header tracking, payload position counting, capture of the
// report id, status and sample bytes, and the final report decode all sit in
// one combinational pass in front of the state and result registers. A result
// (the full latest quaternion, accel and gyro sample) is registered into the
// output register that drives the report channel, or into the skid entry while
// it is stalled, when the last payload byte of a good packet is accepted. The
// input stays ready unless both hold a result that the sink has not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_report_packet_parser (
    input  wire logic    clk,
    input  wire logic    rst_n,
    imurpp_in_if.sink    byte_stream,
    imurpp_out_if.source report
);
    import imurpp_pkg::*;

    localparam logic [2:0] HDR_LEN_LO  = 3'd0;
    localparam logic [2:0] HDR_LEN_HI  = 3'd1;
    localparam logic [2:0] HDR_CHANNEL = 3'd2;
    localparam logic [2:0] HDR_SEQ     = 3'd3;
    localparam logic [2:0] HDR_PAYLOAD = 3'd4;

    logic [2:0]        hdr_reg, hdr_next, hdr_cur;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] chan_reg, chan_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W:0]    pos_inc;
    logic [BYTE_W-1:0] code_reg, code_next;
    logic [BYTE_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0] cap_reg  [CAP_DEPTH];
    logic [BYTE_W-1:0] cap_next [CAP_DEPTH];
    logic [CAP_IDX_W-1:0] cap_idx;
    logic              in_kept;
    word_set_t         words_reg, words_next;
    logic [WORD_W-1:0] sample [4];
    logic              rot_valid_reg, rot_valid_next;

    logic              accept;
    logic [BYTE_W-1:0] data_byte;
    logic              finish;
    logic              produce;
    logic [KIND_W-1:0] kind;
    result_t           new_result;

    result_t           out_reg;
    logic              out_valid_reg;
    result_t           skid_reg;
    logic              skid_valid_reg;
    logic              pop;
    logic              push;

    assign accept    = byte_stream.valid && byte_stream.ready;
    assign data_byte = byte_stream.data_byte;
    assign hdr_cur   = byte_stream.restart ? HDR_LEN_LO : hdr_reg;
    assign pos_inc   = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign cap_idx   = CAP_IDX_W'(pos_reg - FIRST_KEPT);
    assign in_kept   = (pos_reg >= FIRST_KEPT) &&
                       (pos_reg < FIRST_KEPT + LEN_W'(CAP_DEPTH));

    // packet tracking and report decode
    always_comb
    begin
        hdr_next       = hdr_reg;
        len_next       = len_reg;
        chan_next      = chan_reg;
        pos_next       = pos_reg;
        code_next      = code_reg;
        status_next    = status_reg;
        cap_next       = cap_reg;
        words_next     = words_reg;
        rot_valid_next = rot_valid_reg;
        finish         = 1'b0;
        produce        = 1'b0;
        kind           = KIND_ROTATION;

        if (accept)
        begin
            if (byte_stream.restart)
            begin
                hdr_next = HDR_LEN_LO;
            end
            unique case (hdr_cur)
                HDR_LEN_LO:
                begin
                    len_next = {len_reg[LEN_W-1:BYTE_W], data_byte};
                    hdr_next = HDR_LEN_HI;
                end
                HDR_LEN_HI:
                begin
                    len_next = {data_byte, len_reg[BYTE_W-1:0]};
                    hdr_next = HDR_CHANNEL;
                end
                HDR_CHANNEL:
                begin
                    chan_next = data_byte;
                    hdr_next  = HDR_SEQ;
                end
                HDR_SEQ:
                begin
                    pos_next = '0;
                    hdr_next = (len_reg == '0) ? HDR_LEN_LO : HDR_PAYLOAD;
                end
                HDR_PAYLOAD:
                begin
                    if (pos_reg == LEN_W'(0))
                    begin
                        code_next = data_byte;
                    end
                    if (pos_reg == LEN_W'(2))
                    begin
                        status_next = data_byte;
                    end
                    if (in_kept)
                    begin
                        cap_next[cap_idx] = data_byte;
                    end
                    if (pos_inc >= {1'b0, len_reg})
                    begin
                        pos_next = '0;
                        hdr_next = HDR_LEN_LO;
                        finish   = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc[LEN_W-1:0];
                    end
                end
                default:
                begin
                    hdr_next = HDR_LEN_LO;
                end
            endcase
        end

        for (int k = 0; k < 4; k++)
        begin
            sample[k] = {cap_next[2*k+1], cap_next[2*k]};
        end

        if (finish && chan_next == CHANNEL_REPORTS && len_next >= LEN_MIN &&
            status_next == '0)
        begin
            if (code_next == ID_ROTATION && len_next >= LEN_ROTATION)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    words_next[QUAT_BASE+k] = sample[k];
                end
                rot_valid_next = 1'b1;
                produce        = 1'b1;
                kind           = KIND_ROTATION;
            end
            else if (code_next == ID_ACCEL && len_next >= LEN_TRIPLE)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    words_next[ACCEL_BASE+k] = sample[k];
                end
                produce = 1'b1;
                kind    = KIND_ACCEL;
            end
            else if (code_next == ID_GYRO && len_next >= LEN_TRIPLE)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    words_next[GYRO_BASE+k] = sample[k];
                end
                produce = 1'b1;
                kind    = KIND_GYRO;
            end
        end

        new_result.update_kind    = kind;
        new_result.words          = words_next;
        new_result.rotation_valid = rot_valid_next;
    end

    assign pop  = out_valid_reg && report.ready;
    assign push = produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg        <= HDR_LEN_LO;
            len_reg        <= '0;
            chan_reg       <= '0;
            pos_reg        <= '0;
            code_reg       <= '0;
            status_reg     <= '0;
            words_reg      <= '0;
            rot_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            hdr_reg       <= hdr_next;
            len_reg       <= len_next;
            chan_reg      <= chan_next;
            pos_reg       <= pos_next;
            code_reg      <= code_next;
            status_reg    <= status_next;
            words_reg     <= words_next;
            rot_valid_reg <= rot_valid_next;
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= new_result;
            end
            else
            begin
                out_reg <= new_result;
            end
        end
    end

    assign byte_stream.ready     = !skid_valid_reg;
    assign report.valid          = out_valid_reg;
    assign report.update_kind    = out_reg.update_kind;
    assign report.quat_i         = out_reg.words[QUAT_BASE];
    assign report.quat_j         = out_reg.words[QUAT_BASE+1];
    assign report.quat_k         = out_reg.words[QUAT_BASE+2];
    assign report.quat_real      = out_reg.words[QUAT_BASE+3];
    assign report.accel_x        = out_reg.words[ACCEL_BASE];
    assign report.accel_y        = out_reg.words[ACCEL_BASE+1];
    assign report.accel_z        = out_reg.words[ACCEL_BASE+2];
    assign report.gyro_x         = out_reg.words[GYRO_BASE];
    assign report.gyro_y         = out_reg.words[GYRO_BASE+1];
    assign report.gyro_z         = out_reg.words[GYRO_BASE+2];
    assign report.rotation_valid = out_reg.rotation_valid;

endmodule

`default_nettype wire

// ----- sv/imurpp_checker.sv -----
// ----------------------------------------------------------------------------
// imurpp_checker
// Port-level assertions for the sensor report packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

module imurpp_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [imurpp_pkg::KIND_W-1:0] update_kind,
    input wire logic [imurpp_pkg::WORD_W-1:0] quat_i,
    input wire logic                       rotation_valid
);
    import imurpp_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(update_kind) &&
            $stable(quat_i) && $stable(rotation_valid))
    else $error("stalled result changed");

    // only the three update kinds exist
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (update_kind == KIND_ROTATION || update_kind == KIND_ACCEL ||
            update_kind == KIND_GYRO))
    else $error("bad update kind");

    // a rotation update always carries the valid flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && update_kind == KIND_ROTATION |-> rotation_valid)
    else $error("rotation update without valid flag");

    // a new result follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input item");

    // input only stalls while results are buffered
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind imu_report_packet_parser imurpp_checker u_imurpp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (byte_stream.valid),
    .in_ready       (byte_stream.ready),
    .out_valid      (report.valid),
    .out_ready      (report.ready),
    .update_kind    (report.update_kind),
    .quat_i         (report.quat_i),
    .rotation_valid (report.rotation_valid)
);

`default_nettype wire
